>>> src/fbpa_pkg.sv
// Shared types, constants and helpers for the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LINK_W     = IDX_W + 1;
  localparam int STAT_W     = 32;

  localparam logic [LINK_W-1:0] END_MARK     = LINK_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  BLOCKS_LIMIT = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  RESET_BLOCKS = CNT_W'(10);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } fbpa_state_t;

  // Access to the link store: one read and one write port.
  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic              relink;
  } link_req_t;

  typedef struct packed {
    logic              granted;
    logic [IDX_W-1:0]  granted_index;
    logic [CNT_W-1:0]  blocks_free;
    logic [CNT_W-1:0]  lowest_free_seen;
    logic [STAT_W-1:0] alloc_total;
    logic [STAT_W-1:0] release_total;
    logic [STAT_W-1:0] failure_total;
  } fbpa_result_t;

  // Link held right after a relink: one lower, or END_MARK for block 0.
  function automatic logic [LINK_W-1:0] link_init(input logic [IDX_W-1:0] addr);
    logic [LINK_W-1:0] res;
    if (addr == '0) begin
      res = END_MARK;
    end else begin
      res = {1'b0, addr - IDX_W'(1)};
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_blocks(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] res;
    if (v > BLOCKS_LIMIT) begin
      res = BLOCKS_LIMIT;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> src/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator with its output register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   in_     | input     | in_valid / in_ready    | mode, block_index
//   out_    | output    | out_valid / out_ready  | granted, granted_index, counts, totals
//   cfg_    | input     | cfg_valid / cfg_ready  | blocks_in_use
//
// In the accept cycle an allocation reads the head's link from the link RAM;
// in ST_EXEC the pop or push is applied and the result is loaded.
// The output register lets a new item be accepted while a result waits; an
// item in ST_EXEC holds there while the output register is full.
// Reset is synchronous; the link store needs no clearing pass after reset.
module fixed_block_pool_allocator_top import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [IDX_W-1:0]  in_block_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_granted,
  output logic [IDX_W-1:0]  out_granted_index,
  output logic [CNT_W-1:0]  out_blocks_free,
  output logic [CNT_W-1:0]  out_lowest_free_seen,
  output logic [STAT_W-1:0] out_alloc_total,
  output logic [STAT_W-1:0] out_release_total,
  output logic [STAT_W-1:0] out_failure_total,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  link_req_t         link_req;
  logic [LINK_W-1:0] rd_link;
  logic              idle;
  logic              res_valid;
  fbpa_result_t      res;
  fbpa_result_t      out_r;
  logic              out_valid_r;
  logic              slot_free;
  logic              in_fire;
  logic              cfg_fire;

  assign cfg_ready = idle;
  assign in_ready  = idle && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign slot_free = !out_valid_r || out_ready;

  fbpa_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_mode        (in_mode),
    .in_block_index (in_block_index),
    .cfg_fire       (cfg_fire),
    .cfg_data       (cfg_data),
    .slot_free      (slot_free),
    .rd_link        (rd_link),
    .idle           (idle),
    .link_req       (link_req),
    .res_valid      (res_valid),
    .res            (res)
  );

  fbpa_link u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (link_req),
    .rd_link (rd_link)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_granted          = out_r.granted;
  assign out_granted_index    = out_r.granted_index;
  assign out_blocks_free      = out_r.blocks_free;
  assign out_lowest_free_seen = out_r.lowest_free_seen;
  assign out_alloc_total      = out_r.alloc_total;
  assign out_release_total    = out_r.release_total;
  assign out_failure_total    = out_r.failure_total;

endmodule

>>> src/fbpa_ram.sv
// Generic simple dual-port RAM with a registered read.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/fbpa_link.sv
// Link store: next-link RAM plus per-entry valid bits that stand in for a relink.
module fbpa_link import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  link_req_t         req,
  output logic [LINK_W-1:0] rd_link
);

  logic [MAX_BLOCKS-1:0] valid_r;
  logic [MAX_BLOCKS-1:0] valid_nxt;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  rd_valid_r;
  logic [LINK_W-1:0]     ram_q;

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (req.relink) begin
      valid_nxt = '0;
    end else if (req.we) begin
      valid_nxt[req.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Reads and writes never overlap in time, so the valid bit is sampled
  // together with the read and no forwarding is needed.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_addr_r  <= req.raddr;
      rd_valid_r <= valid_r[req.raddr];
    end
  end

  assign rd_link = rd_valid_r ? ram_q : link_init(rd_addr_r);

endmodule

>>> src/fbpa_core.sv
// Allocator control: list head, free count, statistics and the item sequencer.
module fbpa_core import fbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_mode,
  input  logic [IDX_W-1:0]  in_block_index,
  input  logic              cfg_fire,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              slot_free,
  input  logic [LINK_W-1:0] rd_link,
  output logic              idle,
  output link_req_t         link_req,
  output logic              res_valid,
  output fbpa_result_t      res
);

  fbpa_state_t       state_r, state_nxt;
  logic              mode_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  biu_r, biu_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  min_r, min_nxt;
  logic [STAT_W-1:0] alloc_r, alloc_nxt;
  logic [STAT_W-1:0] rel_r, rel_nxt;
  logic [STAT_W-1:0] fail_r, fail_nxt;
  logic [CNT_W-1:0]  cfg_blocks;
  logic              list_empty;
  logic              idx_ok;

  assign cfg_blocks = clamp_blocks(cfg_data);
  assign list_empty = (head_r >= END_MARK);
  assign idx_ok     = ({1'b0, idx_r} < END_MARK);
  assign idle       = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    biu_nxt   = biu_r;
    head_nxt  = head_r;
    free_nxt  = free_r;
    min_nxt   = min_r;
    alloc_nxt = alloc_r;
    rel_nxt   = rel_r;
    fail_nxt  = fail_r;

    link_req        = '0;
    link_req.raddr  = head_r[IDX_W-1:0];
    link_req.waddr  = idx_r;
    link_req.wdata  = head_r;
    link_req.relink = cfg_fire;
    res_valid       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          biu_nxt  = cfg_blocks;
          head_nxt = (cfg_blocks == '0) ? END_MARK : LINK_W'(cfg_blocks - CNT_W'(1));
          free_nxt = cfg_blocks;
        end else if (in_fire) begin
          // Fetch the head's link now so that it is ready in the next cycle.
          link_req.re = (in_mode == MODE_ALLOC);
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
          if (mode_r == MODE_ALLOC) begin
            if (!list_empty) begin
              head_nxt  = rd_link;
              free_nxt  = (free_r != '0) ? free_r - CNT_W'(1) : free_r;
              alloc_nxt = alloc_r + STAT_W'(1);
              if (free_nxt < min_r) begin
                min_nxt = free_nxt;
              end
            end else begin
              fail_nxt = fail_r + STAT_W'(1);
            end
          end else if (idx_ok) begin
            link_req.we = 1'b1;
            head_nxt    = {1'b0, idx_r};
            free_nxt    = (free_r < biu_r) ? free_r + CNT_W'(1) : free_r;
            rel_nxt     = rel_r + STAT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.granted          = (mode_r == MODE_ALLOC) ? !list_empty : idx_ok;
    res.granted_index    = (mode_r == MODE_ALLOC && !list_empty) ? head_r[IDX_W-1:0] : '0;
    res.blocks_free      = free_nxt;
    res.lowest_free_seen = min_nxt;
    res.alloc_total      = alloc_nxt;
    res.release_total    = rel_nxt;
    res.failure_total    = fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      biu_r   <= RESET_BLOCKS;
      head_r  <= LINK_W'(RESET_BLOCKS - CNT_W'(1));
      free_r  <= RESET_BLOCKS;
      min_r   <= RESET_BLOCKS;
      alloc_r <= '0;
      rel_r   <= '0;
      fail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      biu_r   <= biu_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      min_r   <= min_nxt;
      alloc_r <= alloc_nxt;
      rel_r   <= rel_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      idx_r  <= in_block_index;
    end
  end

endmodule

>>> src/fbpa_checker.sv
// Port-level checks for the fixed block pool allocator, bound to the top level.
module fbpa_checker import fbpa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_mode,
  input logic [IDX_W-1:0]  in_block_index,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_granted,
  input logic [IDX_W-1:0]  out_granted_index,
  input logic [CNT_W-1:0]  out_blocks_free,
  input logic [CNT_W-1:0]  out_lowest_free_seen,
  input logic [STAT_W-1:0] out_alloc_total,
  input logic [STAT_W-1:0] out_release_total,
  input logic [STAT_W-1:0] out_failure_total,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [CNT_W-1:0]  cfg_data
);

  // A stalled result keeps its allocation and failure totals.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alloc_total)
      && $stable(out_failure_total))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in progress");

  a_no_cfg_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !(in_valid && in_ready))
    else $error("configuration write and item accepted together");

  a_refused_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_granted_index == '0)
    else $error("refused item carries a nonzero index");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_blocks_free <= BLOCKS_LIMIT)
    else $error("free count above pool size");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the fixed block pool allocator: directed and random traffic.
`timescale 1ns / 1ps

module tb import fbpa_pkg::*; ();

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic              in_mode        = MODE_ALLOC;
  logic [IDX_W-1:0]  in_block_index = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              out_granted;
  logic [IDX_W-1:0]  out_granted_index;
  logic [CNT_W-1:0]  out_blocks_free;
  logic [CNT_W-1:0]  out_lowest_free_seen;
  logic [STAT_W-1:0] out_alloc_total;
  logic [STAT_W-1:0] out_release_total;
  logic [STAT_W-1:0] out_failure_total;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data       = RESET_BLOCKS;

  // Shadow copy of the pool.
  logic [LINK_W-1:0] next_link [MAX_BLOCKS];
  logic [LINK_W-1:0] free_head;
  logic [CNT_W-1:0]  pool_size;
  logic [CNT_W-1:0]  free_now;
  logic [CNT_W-1:0]  free_low;
  logic [STAT_W-1:0] n_alloc;
  logic [STAT_W-1:0] n_release;
  logic [STAT_W-1:0] n_fail;

  fbpa_result_t pending_results[$];
  int           held_blocks[$];
  int           mismatch_count = 0;
  bit           src_steady     = 1'b0;
  bit           sink_steady    = 1'b0;
  bit           sink_hold_req  = 1'b0;

  fixed_block_pool_allocator_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_block_index       (in_block_index),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_granted          (out_granted),
    .out_granted_index    (out_granted_index),
    .out_blocks_free      (out_blocks_free),
    .out_lowest_free_seen (out_lowest_free_seen),
    .out_alloc_total      (out_alloc_total),
    .out_release_total    (out_release_total),
    .out_failure_total    (out_failure_total),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // A pool size write rebuilds the list; the statistics survive it.
  function automatic void relink_pool(input logic [CNT_W-1:0] size_req);
    pool_size = (size_req > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : size_req;
    next_link[0] = END_MARK;
    for (int i = 1; i < MAX_BLOCKS; i++) begin
      next_link[i] = LINK_W'(i - 1);
    end
    free_head = (pool_size == 0) ? END_MARK : LINK_W'(pool_size - 1);
    free_now  = pool_size;
    held_blocks.delete();
  endfunction

  function automatic fbpa_result_t apply_pool_op(input logic mode,
                                                 input logic [IDX_W-1:0] idx);
    fbpa_result_t res;
    logic [IDX_W-1:0] blk;
    res = '0;
    if (mode == MODE_ALLOC) begin
      if (free_head < MAX_BLOCKS) begin
        blk       = free_head[IDX_W-1:0];
        free_head = next_link[blk];
        if (free_now != 0) begin
          free_now = free_now - 1'b1;
        end
        n_alloc = n_alloc + 1'b1;
        if (free_now < free_low) begin
          free_low = free_now;
        end
        res.granted       = 1'b1;
        res.granted_index = blk;
      end else begin
        n_fail = n_fail + 1'b1;
      end
    end else begin
      // Double frees are pushed again; the count just stops at the pool size.
      next_link[idx] = free_head;
      free_head      = {1'b0, idx};
      if (free_now < pool_size) begin
        free_now = free_now + 1'b1;
      end
      n_release   = n_release + 1'b1;
      res.granted = 1'b1;
    end
    res.blocks_free      = free_now;
    res.lowest_free_seen = free_low;
    res.alloc_total      = n_alloc;
    res.release_total    = n_release;
    res.failure_total    = n_fail;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [STAT_W-1:0] exp_v,
                                      input logic [STAT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    fbpa_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got granted %0d index %0d free %0d",
                 $time, out_granted, out_granted_index, out_blocks_free);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("granted", STAT_W'(exp_r.granted), STAT_W'(out_granted));
        check_field("granted_index", STAT_W'(exp_r.granted_index),
                    STAT_W'(out_granted_index));
        check_field("blocks_free", STAT_W'(exp_r.blocks_free), STAT_W'(out_blocks_free));
        check_field("lowest_free_seen", STAT_W'(exp_r.lowest_free_seen),
                    STAT_W'(out_lowest_free_seen));
        check_field("alloc_total", exp_r.alloc_total, out_alloc_total);
        check_field("release_total", exp_r.release_total, out_release_total);
        check_field("failure_total", exp_r.failure_total, out_failure_total);
      end
    end
  end

  // Result side: random stalls, steady stretches, and one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (sink_steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  // Valid is left high after acceptance so back-to-back items need no toggle.
  task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx);
    fbpa_result_t res;
    if (!src_steady) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_block_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_pool_op(mode, idx);
    pending_results.push_back(res);
    if (mode == MODE_ALLOC && res.granted) begin
      held_blocks.push_back(int'(res.granted_index));
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_size(input logic [CNT_W-1:0] size_req);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= size_req;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    relink_pool(size_req);
  endtask

  // Mostly frees of blocks we hold and allocations; the rest is arbitrary.
  task automatic send_random_op(input int noise_pct);
    int pick;
    logic [IDX_W-1:0] idx;
    if ($urandom_range(99) < noise_pct) begin
      send_item(1'($urandom_range(1)), IDX_W'($urandom_range(63)));
    end else if (held_blocks.size() != 0 && $urandom_range(1)) begin
      pick = $urandom_range(held_blocks.size() - 1);
      idx  = IDX_W'(held_blocks[pick]);
      held_blocks.delete(pick);
      send_item(MODE_FREE, idx);
    end else begin
      send_item(MODE_ALLOC, IDX_W'($urandom_range(63)));
    end
  endtask

  // The reset pool hands out blocks from the top down, then refuses.
  task automatic test_drain_from_reset();
    repeat (11) send_item(MODE_ALLOC, IDX_W'($urandom_range(63)));
  endtask

  task automatic test_release_outside_pool();
    send_item(MODE_FREE, 6'd63);
    send_item(MODE_FREE, 6'd0);
    send_item(MODE_ALLOC, 6'd0);
    send_item(MODE_ALLOC, 6'd63);
  endtask

  // Freeing one block twice makes the list loop on itself, so allocations
  // keep succeeding while the free count sits at zero.
  task automatic test_double_free();
    write_pool_size(CNT_W'(1));
    send_item(MODE_FREE, 6'd5);
    send_item(MODE_FREE, 6'd5);
    repeat (3) send_item(MODE_ALLOC, 6'd0);
  endtask

  task automatic test_pool_size_extremes();
    write_pool_size(CNT_W'(0));
    send_item(MODE_ALLOC, 6'd0);
    send_item(MODE_FREE, 6'd42);
    send_item(MODE_ALLOC, 6'd0);
    write_pool_size(CNT_W'(127));
    send_item(MODE_ALLOC, 6'd0);
    write_pool_size(CNT_W'(MAX_BLOCKS));
    send_item(MODE_ALLOC, 6'd0);
  endtask

  task automatic test_output_backpressure();
    write_pool_size(CNT_W'(MAX_BLOCKS));
    sink_hold_req = 1'b1;
    repeat (40) send_random_op(10);
  endtask

  task automatic test_random_traffic();
    int size_req;
    for (int phase = 0; phase < 12; phase++) begin
      if ($urandom_range(3) == 0) begin
        size_req = $urandom_range(127);
      end else begin
        size_req = $urandom_range(64, 1);
      end
      write_pool_size(CNT_W'(size_req));
      src_steady  = (phase == 5);
      sink_steady = (phase == 5);
      repeat (68) send_random_op(25);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    relink_pool(RESET_BLOCKS);
    free_low  = RESET_BLOCKS;
    n_alloc   = '0;
    n_release = '0;
    n_fail    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_drain_from_reset();
    test_release_outside_pool();
    test_double_free();
    test_pool_size_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fixed_block_pool_allocator_top verification clean");
    end else begin
      $display("fixed_block_pool_allocator_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fixed_block_pool_allocator_top verification failed");
    $finish;
  end

endmodule

>>> fixed_block_pool_allocator_top.f
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fbpa_link.sv
src/fbpa_core.sv
src/fixed_block_pool_allocator_top.sv
src/fbpa_checker.sv
tb/tb.sv
